// File: hw/rtl/gtc_pkg.sv
// Shared widths, constants, types and the month start table for the GPS time converter.
package gtc_pkg;

  // Port field widths
  localparam int WEEK_W  = 14;
  localparam int MS_W    = 30;
  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SECMS_W = 16;

  // Internal widths
  localparam int MINS_W = 15;  // whole minutes in the week field
  localparam int HRS_W  = 9;   // whole hours in the week field
  localparam int DAYS_W = 5;   // whole days in the week field
  localparam int C_W    = 22;  // shifted Julian day number
  localparam int N_W    = 28;  // 100 * c - 12210
  localparam int D_W    = 13;  // Julian-style year count
  localparam int DOY_W  = 9;   // days left after the year is removed
  localparam int F_W    = 5;   // month index of the Julian-day method
  localparam int NUMF_W = 23;  // 10000 * days left

  // Pipeline depth
  localparam int TOD_STG  = 6;
  localparam int DATE_STG = 8;
  localparam int NSTG     = TOD_STG + DATE_STG;

  // Constant divisors
  localparam int MS_PER_MIN   = 60000;
  localparam int MIN_PER_HR   = 60;
  localparam int HR_PER_DAY   = 24;
  localparam int YEAR_X100    = 36525;
  localparam int MONTH_X10K   = 306001;
  localparam int MONTH_SCALE  = 10000;

  // Day number arithmetic
  localparam int DAYS_PER_WEEK = 7;
  localparam int DAYS_PER_YEAR = 365;
  localparam int C_OFS         = 2445782;    // GPS epoch Julian day plus 1537
  localparam int N_WEEK        = 700;
  localparam int N_DAY         = 100;
  localparam int N_OFS         = 244565990;  // 100 * C_OFS - 12210
  localparam int YEAR_OFS      = 4715;
  localparam int MONTH_WRAP    = 14;
  localparam int MONTH_LO_OFS  = 1;
  localparam int MONTH_HI_OFS  = 13;
  localparam int MONTH_FEB     = 2;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECMS_W-1:0] second_ms;
  } tod_t;

  // floor(30.6001 * f)
  function automatic logic [DOY_W-1:0] month_start(input logic [F_W-1:0] f);
    logic [DOY_W-1:0] o;
    case (f)
      5'd0:    o = 9'd0;
      5'd1:    o = 9'd30;
      5'd2:    o = 9'd61;
      5'd3:    o = 9'd91;
      5'd4:    o = 9'd122;
      5'd5:    o = 9'd153;
      5'd6:    o = 9'd183;
      5'd7:    o = 9'd214;
      5'd8:    o = 9'd244;
      5'd9:    o = 9'd275;
      5'd10:   o = 9'd306;
      5'd11:   o = 9'd336;
      5'd12:   o = 9'd367;
      5'd13:   o = 9'd397;
      5'd14:   o = 9'd428;
      5'd15:   o = 9'd459;
      default: o = 9'd0;
    endcase
    return o;
  endfunction

endpackage

// File: hw/rtl/gtc_in_if.sv
// Input channel: GPS week and time of week.
interface gtc_in_if import gtc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [WEEK_W-1:0] gps_week;
  logic [MS_W-1:0]   week_ms;

  modport source(output valid, output gps_week, output week_ms, input ready);
  modport sink(input valid, input gps_week, input week_ms, output ready);
endinterface

// File: hw/rtl/gtc_out_if.sv
// Result channel: calendar date and time of day.
interface gtc_out_if import gtc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [YEAR_W-1:0]  year;
  logic [MONTH_W-1:0] month;
  logic [DAY_W-1:0]   day;
  logic [HOUR_W-1:0]  hour;
  logic [MIN_W-1:0]   minute;
  logic [SECMS_W-1:0] second_ms;

  modport source(output valid, output year, output month, output day, output hour,
                 output minute, output second_ms, input ready);
  modport sink(input valid, input year, input month, input day, input hour,
               input minute, input second_ms, output ready);
endinterface

// File: hw/rtl/gtc_cdiv.sv
// Two-stage divide by a constant: reciprocal multiply, then one correction step.
module gtc_cdiv #(
  parameter int NUM_W = 30,
  parameter int DIV   = 60000,
  parameter int QUO_W = NUM_W - $clog2(DIV) + 1,
  parameter int REM_W = $clog2(DIV)
) (
  input  logic             clk,
  input  logic [1:0]       en,
  input  logic [NUM_W-1:0] num,
  output logic [QUO_W-1:0] quo,
  output logic [REM_W-1:0] rem
);

  // floor(2^NUM_W / DIV) underestimates the quotient by at most one
  localparam longint unsigned RECIP = (64'd1 << NUM_W) / DIV;
  localparam int MUL_W  = $clog2(RECIP + 1);
  localparam int PROD_W = NUM_W + MUL_W;
  localparam logic [MUL_W-1:0] RECIP_V = MUL_W'(RECIP);
  localparam logic [NUM_W:0]   DIV_V   = (NUM_W + 1)'(DIV);

  logic [PROD_W-1:0] prod;
  logic [QUO_W-1:0]  q0_nxt, q0_r;
  logic [NUM_W-1:0]  num_r;
  logic [NUM_W:0]    back, r0;
  logic              fix;
  logic [QUO_W-1:0]  quo_nxt, quo_r;
  logic [REM_W-1:0]  rem_nxt, rem_r;

  always_comb begin
    prod   = PROD_W'(num) * PROD_W'(RECIP_V);
    q0_nxt = QUO_W'(prod >> NUM_W);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_r <= num;
      q0_r  <= q0_nxt;
    end
  end

  always_comb begin
    back    = (NUM_W + 1)'(q0_r) * DIV_V;
    r0      = {1'b0, num_r} - back;
    fix     = (r0 >= DIV_V);
    quo_nxt = q0_r + QUO_W'(fix);
    rem_nxt = fix ? REM_W'(r0 - DIV_V) : REM_W'(r0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

// File: hw/rtl/gtc_tod.sv
// Time-of-week split into whole days, hour, minute and milliseconds.
module gtc_tod import gtc_pkg::*; (
  input  logic                clk,
  input  logic [TOD_STG-1:0]  en,
  input  logic [WEEK_W-1:0]   gps_week,
  input  logic [MS_W-1:0]     week_ms,
  output logic [WEEK_W-1:0]   week,
  output logic [DAYS_W-1:0]   days,
  output tod_t                tod
);

  logic [MINS_W-1:0]  mins;
  logic [SECMS_W-1:0] sec;
  logic [HRS_W-1:0]   hrs;
  logic [MIN_W-1:0]   minute;
  logic [HOUR_W-1:0]  hour;

  logic [WEEK_W-1:0]  week_r   [TOD_STG];
  logic [SECMS_W-1:0] sec_r    [2:5];
  logic [MIN_W-1:0]   minute_r [4:5];

  gtc_cdiv #(.NUM_W(MS_W), .DIV(MS_PER_MIN), .QUO_W(MINS_W), .REM_W(SECMS_W)) u_min (
    .clk(clk), .en(en[1:0]), .num(week_ms), .quo(mins), .rem(sec)
  );

  gtc_cdiv #(.NUM_W(MINS_W), .DIV(MIN_PER_HR), .QUO_W(HRS_W), .REM_W(MIN_W)) u_hr (
    .clk(clk), .en(en[3:2]), .num(mins), .quo(hrs), .rem(minute)
  );

  gtc_cdiv #(.NUM_W(HRS_W), .DIV(HR_PER_DAY), .QUO_W(DAYS_W), .REM_W(HOUR_W)) u_day (
    .clk(clk), .en(en[5:4]), .num(hrs), .quo(days), .rem(hour)
  );

  always_ff @(posedge clk) begin
    if (en[0]) week_r[0] <= gps_week;
    for (int i = 1; i < TOD_STG; i++) begin
      if (en[i]) week_r[i] <= week_r[i-1];
    end
    if (en[2]) sec_r[2] <= sec;
    for (int i = 3; i <= 5; i++) begin
      if (en[i]) sec_r[i] <= sec_r[i-1];
    end
    if (en[4]) minute_r[4] <= minute;
    if (en[5]) minute_r[5] <= minute_r[4];
  end

  assign week          = week_r[TOD_STG-1];
  assign tod.hour      = hour;
  assign tod.minute    = minute_r[5];
  assign tod.second_ms = sec_r[5];

endmodule

// File: hw/rtl/gtc_date.sv
// Day number to Gregorian year, month and day by the Julian-day method.
module gtc_date import gtc_pkg::*; (
  input  logic                clk,
  input  logic [DATE_STG-1:0] en,
  input  logic [WEEK_W-1:0]   week,
  input  logic [DAYS_W-1:0]   days,
  input  tod_t                tod_in,
  output logic [YEAR_W-1:0]   year,
  output logic [MONTH_W-1:0]  month,
  output logic [DAY_W-1:0]    day,
  output tod_t                tod_out
);

  logic [N_W-1:0]     n_nxt, n_r;
  logic [C_W-1:0]     c_nxt;
  logic [C_W-1:0]     c_r   [0:2];
  logic [D_W-1:0]     d;
  logic [D_W-1:0]     d_r   [3:6];
  logic [DOY_W-1:0]   doy_nxt;
  logic [DOY_W-1:0]   doy_r [3:6];
  logic [NUMF_W-1:0]  numf_nxt, numf_r;
  logic [F_W-1:0]     f;
  logic [MONTH_W-1:0] month_nxt, month_r;
  logic [YEAR_W-1:0]  year_nxt, year_r;
  logic [DAY_W-1:0]   day_nxt, day_r;
  tod_t               tod_r [DATE_STG];

  // c = 7w + days + offset; n = 100c - 12210 built straight from the inputs
  always_comb begin
    c_nxt = C_W'(week) * C_W'(DAYS_PER_WEEK) + C_W'(days) + C_W'(C_OFS);
    n_nxt = N_W'(week) * N_W'(N_WEEK) + N_W'(days) * N_W'(N_DAY) + N_W'(N_OFS);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      n_r    <= n_nxt;
      c_r[0] <= c_nxt;
    end
    if (en[1]) c_r[1] <= c_r[0];
    if (en[2]) c_r[2] <= c_r[1];
  end

  gtc_cdiv #(.NUM_W(N_W), .DIV(YEAR_X100), .QUO_W(D_W)) u_yr (
    .clk(clk), .en(en[2:1]), .num(n_r), .quo(d), .rem()
  );

  always_comb begin
    doy_nxt  = DOY_W'(c_r[2] - C_W'(d) * C_W'(DAYS_PER_YEAR) - C_W'(d >> 2));
    numf_nxt = NUMF_W'(doy_r[3]) * NUMF_W'(MONTH_SCALE);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      d_r[3]   <= d;
      doy_r[3] <= doy_nxt;
    end
    if (en[4]) numf_r <= numf_nxt;
    for (int i = 4; i <= 6; i++) begin
      if (en[i]) begin
        d_r[i]   <= d_r[i-1];
        doy_r[i] <= doy_r[i-1];
      end
    end
  end

  gtc_cdiv #(.NUM_W(NUMF_W), .DIV(MONTH_X10K), .QUO_W(F_W)) u_mon (
    .clk(clk), .en(en[6:5]), .num(numf_r), .quo(f), .rem()
  );

  // month index runs 4..15 from March; indices 14 and 15 fold into Jan/Feb of the next year
  always_comb begin
    day_nxt   = DAY_W'(doy_r[6] - month_start(f));
    month_nxt = (f < F_W'(MONTH_WRAP)) ? MONTH_W'(f - F_W'(MONTH_LO_OFS))
                                        : MONTH_W'(f - F_W'(MONTH_HI_OFS));
    year_nxt  = YEAR_W'(d_r[6] - D_W'(YEAR_OFS) - D_W'(month_nxt > MONTH_W'(MONTH_FEB)));
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
    if (en[0]) tod_r[0] <= tod_in;
    for (int i = 1; i < DATE_STG; i++) begin
      if (en[i]) tod_r[i] <= tod_r[i-1];
    end
  end

  assign year    = year_r;
  assign month   = month_r;
  assign day     = day_r;
  assign tod_out = tod_r[DATE_STG-1];

endmodule

// File: hw/rtl/gps_time_to_calendar.sv
// GPS week and time of week to Gregorian date and time of day.
// Each beat passes through the time-of-day stages, then the date stages, to the result.
// Throughput: one beat per cycle; each stage has its own valid bit and loads when it is
// empty or the stage after it is empty or moving, so bubbles close up behind a stalled output.
// Reset clears the stage valid bits only; the data registers are not reset.
module gps_time_to_calendar import gtc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gtc_in_if.sink    in_bus,
  gtc_out_if.source out_bus
);

  logic [NSTG-1:0]   v_r;
  logic [NSTG:0]     rdy;
  logic [WEEK_W-1:0] week;
  logic [DAYS_W-1:0] days;
  tod_t              tod_mid, tod_end;

  always_comb begin
    rdy[NSTG] = out_bus.ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= in_bus.valid;
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) v_r[i] <= v_r[i-1];
      end
    end
  end

  gtc_tod u_tod (
    .clk(clk),
    .en(rdy[TOD_STG-1:0]),
    .gps_week(in_bus.gps_week),
    .week_ms(in_bus.week_ms),
    .week(week),
    .days(days),
    .tod(tod_mid)
  );

  gtc_date u_date (
    .clk(clk),
    .en(rdy[NSTG-1:TOD_STG]),
    .week(week),
    .days(days),
    .tod_in(tod_mid),
    .year(out_bus.year),
    .month(out_bus.month),
    .day(out_bus.day),
    .tod_out(tod_end)
  );

  assign in_bus.ready      = rdy[0];
  assign out_bus.valid     = v_r[NSTG-1];
  assign out_bus.hour      = tod_end.hour;
  assign out_bus.minute    = tod_end.minute;
  assign out_bus.second_ms = tod_end.second_ms;

endmodule

// File: hw/rtl/gtc_checker.sv
// Port-level checks for the GPS time converter, bound to the top level.
module gtc_checker import gtc_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [YEAR_W-1:0]  out_year,
  input logic [MONTH_W-1:0] out_month,
  input logic [DAY_W-1:0]   out_day,
  input logic [HOUR_W-1:0]  out_hour,
  input logic [MIN_W-1:0]   out_minute,
  input logic [SECMS_W-1:0] out_second_ms
);

  localparam int CNT_W = $clog2(NSTG + 2);

  logic             in_acc, out_acc;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);
  end

  // beats in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result shown with no beat in flight");

  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !out_acc) |-> cnt_r < CNT_W'(NSTG))
    else $error("more beats taken than the pipeline holds");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day) && $stable(out_hour) && $stable(out_minute)
      && $stable(out_second_ms))
    else $error("stalled result beat changed");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day != '0
      && out_hour < 5'd24 && out_minute < 6'd60 && out_second_ms < 16'd60000))
    else $error("result field out of calendar range");

endmodule

bind gps_time_to_calendar gtc_checker u_gtc_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_bus.valid),
  .in_ready(in_bus.ready),
  .out_valid(out_bus.valid),
  .out_ready(out_bus.ready),
  .out_year(out_bus.year),
  .out_month(out_bus.month),
  .out_day(out_bus.day),
  .out_hour(out_bus.hour),
  .out_minute(out_bus.minute),
  .out_second_ms(out_bus.second_ms)
);

// File: bench/gps_time_to_calendar_test.sv
// Testbench for the GPS week and time of week to Gregorian calendar converter.
module gps_time_to_calendar_test import gtc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned MS_DAY    = 86400000;
  localparam longint unsigned MS_HOUR   = 3600000;
  localparam longint unsigned MS_MINUTE = 60000;
  localparam longint unsigned WEEK_MS   = 604800000;
  localparam longint unsigned MS_TOP    = (1 << MS_W) - 1;
  localparam longint unsigned JD_BASE   = 2445782;  // GPS epoch day plus the 1537 shift
  localparam int RANDOM_PER_PHASE = 125;
  localparam int STALL_LIMIT      = 5000;
  localparam int SEND_GAP   [4] = '{0, 75, 0, 36};
  localparam int RECV_STALL [4] = '{0, 0, 75, 36};

  typedef struct packed {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SECMS_W-1:0] second_ms;
  } cal_t;

  typedef struct packed {
    logic [WEEK_W-1:0] week;
    logic [MS_W-1:0]   ms;
    logic              typed;  // row carries its own expected date
    cal_t              cal;
  } probe_t;

  localparam int N_PROBES = 22;
  localparam probe_t PROBES [N_PROBES] = '{
    '{14'd0,     30'd0,          1'b1, '{12'd1980, 4'd1,  5'd6,  5'd0,  6'd0,  16'd0}},
    '{14'd0,     30'd604799999,  1'b1, '{12'd1980, 4'd1,  5'd12, 5'd23, 6'd59, 16'd59999}},
    // beyond one week: whole days roll into the date
    '{14'd0,     30'd1073741823, 1'b1, '{12'd1980, 4'd1,  5'd18, 5'd10, 6'd15, 16'd41823}},
    '{14'd0,     30'd59999,      1'b1, '{12'd1980, 4'd1,  5'd6,  5'd0,  6'd0,  16'd59999}},
    '{14'd0,     30'd60000,      1'b1, '{12'd1980, 4'd1,  5'd6,  5'd0,  6'd1,  16'd0}},
    '{14'd0,     30'd3599999,    1'b1, '{12'd1980, 4'd1,  5'd6,  5'd0,  6'd59, 16'd59999}},
    '{14'd0,     30'd86399999,   1'b1, '{12'd1980, 4'd1,  5'd6,  5'd23, 6'd59, 16'd59999}},
    '{14'd0,     30'd86400000,   1'b1, '{12'd1980, 4'd1,  5'd7,  5'd0,  6'd0,  16'd0}},
    '{14'd7,     30'd432000000,  1'b1, '{12'd1980, 4'd2,  5'd29, 5'd0,  6'd0,  16'd0}},
    '{14'd7,     30'd518400000,  1'b1, '{12'd1980, 4'd3,  5'd1,  5'd0,  6'd0,  16'd0}},
    '{14'd51,    30'd259200000,  1'b1, '{12'd1980, 4'd12, 5'd31, 5'd0,  6'd0,  16'd0}},
    '{14'd51,    30'd345600000,  1'b1, '{12'd1981, 4'd1,  5'd1,  5'd0,  6'd0,  16'd0}},
    '{14'd16383, 30'd0,          1'b0, '0},
    '{14'd16383, 30'd604799999,  1'b0, '0},
    '{14'd16383, 30'd1073741823, 1'b0, '0},
    '{14'd3,     30'd604799999,  1'b0, '0},
    '{14'd1023,  30'd604799999,  1'b0, '0},
    '{14'd1024,  30'd0,          1'b0, '0},
    '{14'd2047,  30'd604799999,  1'b0, '0},
    '{14'd2048,  30'd0,          1'b0, '0},
    '{14'd8191,  30'd536870912,  1'b0, '0},
    '{14'd10922, 30'd715827882,  1'b0, '0}
  };

  logic clk;
  logic rst_n;

  gtc_in_if  in_bus();
  gtc_out_if out_bus();

  gps_time_to_calendar u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  cal_t pending_dates [$];
  int   mismatch_count = 0;
  int   quiet_cycles   = 0;
  int   send_gap_pct   = 0;
  int   recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Julian-day split of the shifted day number, then time of day
  function automatic cal_t gregorian_of(input logic [WEEK_W-1:0] week,
                                        input logic [MS_W-1:0] ms);
    longint unsigned jd, yr_cnt, yr_start, left, mon_idx, mon, yr, wms;
    cal_t r;
    wms      = ms;
    jd       = 7 * longint'(week) + wms / MS_DAY + JD_BASE;
    yr_cnt   = (100 * jd - 12210) / 36525;
    yr_start = 365 * yr_cnt + yr_cnt / 4;
    left     = jd - yr_start;
    mon_idx  = (10000 * left) / 306001;
    mon      = mon_idx - 1 - 12 * (mon_idx / 14);
    yr       = yr_cnt - 4715 - (7 + mon) / 10;
    r.year      = yr[YEAR_W-1:0];
    r.month     = mon[MONTH_W-1:0];
    r.day       = DAY_W'(left - (306001 * mon_idx) / 10000);
    r.hour      = HOUR_W'((wms / MS_HOUR) % 24);
    r.minute    = MIN_W'((wms / MS_MINUTE) % 60);
    r.second_ms = SECMS_W'(wms % MS_MINUTE);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want !== got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic send_beat(input logic [WEEK_W-1:0] week, input logic [MS_W-1:0] ms,
                           input logic typed, input cal_t typed_cal);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_bus.valid    <= 1'b0;
      in_bus.gps_week <= WEEK_W'($urandom);
      in_bus.week_ms  <= MS_W'($urandom);
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.gps_week <= week;
    in_bus.week_ms  <= ms;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    pending_dates.push_back(typed ? typed_cal : gregorian_of(week, ms));
  endtask

  // receiver back-pressure
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result check and stall watchdog
  always @(posedge clk) begin
    cal_t want;
    bit   moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      if (in_bus.valid === 1'b1 && in_bus.ready === 1'b1)
        moved = 1'b1;
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        moved = 1'b1;
        if (pending_dates.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result beat, expected none, actual %0d-%0d-%0d",
                   $time, out_bus.year, out_bus.month, out_bus.day);
        end else begin
          want = pending_dates.pop_front();
          check_field("year",      want.year,      out_bus.year);
          check_field("month",     want.month,     out_bus.month);
          check_field("day",       want.day,       out_bus.day);
          check_field("hour",      want.hour,      out_bus.hour);
          check_field("minute",    want.minute,    out_bus.minute);
          check_field("second_ms", want.second_ms, out_bus.second_ms);
        end
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_dates.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    logic [WEEK_W-1:0] week;
    logic [MS_W-1:0]   ms;
    int                pick;
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.gps_week <= '0;
    in_bus.week_ms  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (PROBES[i])
      send_beat(PROBES[i].week, PROBES[i].ms, PROBES[i].typed, PROBES[i].cal);

    for (int phase = 0; phase < 4; phase++) begin
      send_gap_pct   = SEND_GAP[phase];
      recv_stall_pct = RECV_STALL[phase];
      repeat (RANDOM_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        week = WEEK_W'($urandom_range(0, (1 << WEEK_W) - 1));
        if (pick < 70)
          ms = MS_W'($urandom_range(0, WEEK_MS - 1));
        else if (pick < 82)  // minute edges
          ms = MS_W'($urandom_range(0, 10079) * MS_MINUTE + ($urandom_range(0, 1) ? 59999 : 0));
        else
          ms = MS_W'($urandom_range(WEEK_MS, MS_TOP));
        send_beat(week, ms, 1'b0, '0);
      end
    end
    in_bus.valid <= 1'b0;

    while (pending_dates.size() != 0) @(posedge clk);
    repeat (NSTG + 4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
